[design/bdfb_pkg.sv]
package bdfb_pkg;

    localparam int PAT_W   = 8;
    localparam int ATTR_W  = 24;
    localparam int COORD_W = 16;
    localparam int GLYPH_W = 14;
    localparam int DIM_W   = 9;
    localparam int CFG_IDX_W = 1;

    localparam logic [GLYPH_W-1:0] GLYPH_BASE = 14'h2800;
    localparam logic [DIM_W-1:0]   DIM_RESET  = 9'd256;

    typedef enum logic [2:0] {
        OP_CLEAR   = 3'd0,
        OP_PLOT    = 3'd1,
        OP_TEST    = 3'd2,
        OP_SETATTR = 3'd3,
        OP_READ    = 3'd4
    } opcode_t;

    localparam logic [CFG_IDX_W-1:0] CFG_AREA_W = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_AREA_H = 1'd1;

    // braille dot numbering inside a 2x4 cell, indexed by {y[1:0], x[0]}
    function automatic logic [PAT_W-1:0] dot_mask(input logic [2:0] pos);
        logic [2:0] sel;
        case (pos)
            3'd0:    sel = 3'd0;
            3'd1:    sel = 3'd3;
            3'd2:    sel = 3'd1;
            3'd3:    sel = 3'd4;
            3'd4:    sel = 3'd2;
            3'd5:    sel = 3'd5;
            3'd6:    sel = 3'd6;
            3'd7:    sel = 3'd7;
            default: sel = 3'd0;
        endcase
        dot_mask = PAT_W'(1) << sel;
    endfunction

endpackage

[design/braille_dot_framebuffer_top.sv]
// Braille dot framebuffer, 2x4 dots per cell, one pattern and attribute word per cell.
// Plot, test, set-attribute and read: the cell is read when the input word is accepted,
// then modified, written back and the result registered, stalling while the output is full;
// no new word is taken until then. Clear: a fill sweep writes every cell, then the cell is read.
// Reset: control and output valid cleared, drawing area width/height back to 256 dots;
// cell contents are undefined until the first clear.
module braille_dot_framebuffer_top
    import bdfb_pkg::*;
#(
    parameter int MAX_CELL_COLS = 128,
    parameter int MAX_CELL_ROWS = 64
)
(
    input  logic                 clk,
    input  logic                 rst_n,

    // command stream
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // dot_x[15:0], dot_y[31:16], dot_on[32], fill_pattern[40:33],
    // attr_first[48:41], attr_second[56:49], attr_third[64:57], zero pad
    input  logic [71:0]          s_tdata,
    // opcode[2:0]
    input  logic [2:0]           s_tuser,

    // result stream
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // dot_is_set[0], cell_pattern[8:1], glyph_code[22:9],
    // cell_attr_first[30:23], cell_attr_second[38:31], cell_attr_third[46:39], zero pad
    output logic [47:0]          m_tdata,
    // in_range[0]
    output logic                 m_tuser,

    // register writes
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [DIM_W-1:0]     cfg_data
);

    localparam int DEPTH = MAX_CELL_COLS * MAX_CELL_ROWS;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW    = (MAX_CELL_COLS > 1) ? $clog2(MAX_CELL_COLS) : 1;
    localparam int RW    = (MAX_CELL_ROWS > 1) ? $clog2(MAX_CELL_ROWS) : 1;

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_CLEAR = 4'b0010,   // fill sweep over the whole store
        ST_READ  = 4'b0100,   // read the addressed cell after a clear
        ST_MOD   = 4'b1000    // read data back: modify, write back, report
    } state_t;

    state_t state_reg, state_next;

    // configuration
    logic [DIM_W-1:0] area_w_reg, area_h_reg;

    // latched command
    opcode_t           op_reg;
    logic              on_reg;
    logic [PAT_W-1:0]  fill_reg;
    logic [ATTR_W-1:0] attr_reg;
    logic [AW-1:0]     addr_reg;
    logic              hit_reg;
    logic [PAT_W-1:0]  mask_reg;

    logic [AW-1:0] clr_cnt_reg, clr_cnt_next;

    // output register
    logic              m_valid_reg, m_valid_next;
    logic              out_range_reg;
    logic              out_set_reg;
    logic [PAT_W-1:0]  out_pat_reg;
    logic [ATTR_W-1:0] out_attr_reg;

    // unpacked input word
    logic [COORD_W-1:0] in_x, in_y;
    logic               in_on;
    logic [PAT_W-1:0]   in_fill;
    logic [ATTR_W-1:0]  in_attr;

    assign in_x    = s_tdata[15:0];
    assign in_y    = s_tdata[31:16];
    assign in_on   = s_tdata[32];
    assign in_fill = s_tdata[40:33];
    assign in_attr = s_tdata[64:41];

    // grid size in cells, saturated at the store's geometry
    logic [DIM_W:0]    cols_raw, rows_raw;
    logic [COORD_W-1:0] grid_cols, grid_rows;

    assign cols_raw = ({1'b0, area_w_reg} + (DIM_W+1)'(1)) >> 1;
    assign rows_raw = ({1'b0, area_h_reg} + (DIM_W+1)'(3)) >> 2;

    always_comb
    begin
        grid_cols = (COORD_W'(cols_raw) > COORD_W'(MAX_CELL_COLS))
                  ? COORD_W'(MAX_CELL_COLS) : COORD_W'(cols_raw);
        grid_rows = (COORD_W'(rows_raw) > COORD_W'(MAX_CELL_ROWS))
                  ? COORD_W'(MAX_CELL_ROWS) : COORD_W'(rows_raw);
    end

    // address decode straight off the input word; negatives are always outside
    logic          in_hit;
    logic [AW-1:0] in_addr;
    logic [CW-1:0] in_col;
    logic [RW-1:0] in_row;

    assign in_col  = in_x[CW:1];
    assign in_row  = in_y[RW+1:2];
    assign in_hit  = !in_x[COORD_W-1] && !in_y[COORD_W-1]
                  && ({1'b0, in_x[COORD_W-1:1]} < grid_cols)
                  && ({2'b0, in_y[COORD_W-1:2]} < grid_rows);
    assign in_addr = AW'(AW'(in_row) * AW'(MAX_CELL_COLS)) + AW'(in_col);

    logic accept;
    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;

    // store access
    logic              wr_en, rd_en;
    logic [AW-1:0]     wr_addr, rd_addr;
    logic [PAT_W-1:0]  wr_pat, rd_pat, new_pat;
    logic [ATTR_W-1:0] wr_attr, rd_attr, new_attr;
    logic              out_free;

    assign out_free = !m_valid_reg || m_tready;

    // read issued in the accept cycle, or after a clear from the latched address
    assign rd_en   = accept || (state_reg == ST_READ);
    assign rd_addr = (state_reg == ST_READ) ? addr_reg : in_addr;

    always_comb
    begin
        new_pat  = rd_pat;
        new_attr = rd_attr;
        if (op_reg == OP_PLOT)
        begin
            new_pat = on_reg ? (rd_pat | mask_reg) : (rd_pat & ~mask_reg);
        end
        if (op_reg == OP_SETATTR)
        begin
            new_attr = attr_reg;
        end
    end

    always_comb
    begin
        wr_en   = 1'b0;
        wr_addr = addr_reg;
        wr_pat  = new_pat;
        wr_attr = new_attr;
        if (state_reg == ST_CLEAR)
        begin
            wr_en   = 1'b1;
            wr_addr = clr_cnt_reg;
            wr_pat  = fill_reg;
            wr_attr = '0;
        end
        else if (state_reg == ST_MOD)
        begin
            // write back only in the cycle the result is loaded into the output register
            wr_en = out_free && hit_reg && (op_reg == OP_PLOT || op_reg == OP_SETATTR);
        end
    end

    bdfb_store #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_store (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_pat  (wr_pat),
        .wr_attr (wr_attr),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_pat  (rd_pat),
        .rd_attr (rd_attr)
    );

    // sequencer
    logic load_out;

    always_comb
    begin
        state_next   = state_reg;
        clr_cnt_next = clr_cnt_reg;
        load_out     = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    clr_cnt_next = '0;
                    state_next   = (opcode_t'(s_tuser) == OP_CLEAR) ? ST_CLEAR : ST_MOD;
                end
            end
            ST_CLEAR:
            begin
                clr_cnt_next = clr_cnt_reg + AW'(1);
                if (clr_cnt_reg == AW'(DEPTH - 1))
                begin
                    state_next = ST_READ;
                end
            end
            ST_READ:
            begin
                state_next = ST_MOD;
            end
            ST_MOD:
            begin
                if (out_free)
                begin
                    load_out   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        m_valid_next = m_valid_reg;
        if (load_out)
        begin
            m_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            clr_cnt_reg <= '0;
            m_valid_reg <= 1'b0;
            area_w_reg  <= DIM_RESET;
            area_h_reg  <= DIM_RESET;
        end
        else
        begin
            state_reg   <= state_next;
            clr_cnt_reg <= clr_cnt_next;
            m_valid_reg <= m_valid_next;
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == CFG_AREA_W)
                begin
                    area_w_reg <= cfg_data;
                end
                if (cfg_index == CFG_AREA_H)
                begin
                    area_h_reg <= cfg_data;
                end
            end
        end
    end

    // payload, no reset
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg   <= opcode_t'(s_tuser);
            on_reg   <= in_on;
            fill_reg <= in_fill;
            attr_reg <= in_attr;
            addr_reg <= in_addr;
            hit_reg  <= in_hit;
            mask_reg <= dot_mask({in_y[1:0], in_x[0]});
        end
        if (load_out)
        begin
            // outside the grid reports zero range, dot, pattern and attributes
            out_range_reg <= hit_reg;
            out_set_reg   <= hit_reg && ((new_pat & mask_reg) != '0);
            out_pat_reg   <= hit_reg ? new_pat : '0;
            out_attr_reg  <= hit_reg ? new_attr : '0;
        end
    end

    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_valid_reg;
    assign m_tuser   = out_range_reg;
    assign m_tdata   = {1'b0, out_attr_reg, GLYPH_BASE + GLYPH_W'(out_pat_reg),
                        out_pat_reg, out_set_reg};

endmodule

[design/bdfb_store.sv]
module bdfb_store
    import bdfb_pkg::*;
#(
    parameter int DEPTH = 8192,
    parameter int AW    = 13
)
(
    input  logic              clk,
    input  logic              wr_en,
    input  logic [AW-1:0]     wr_addr,
    input  logic [PAT_W-1:0]  wr_pat,
    input  logic [ATTR_W-1:0] wr_attr,
    input  logic              rd_en,
    input  logic [AW-1:0]     rd_addr,
    output logic [PAT_W-1:0]  rd_pat,
    output logic [ATTR_W-1:0] rd_attr
);

    logic [PAT_W-1:0]  pat_mem  [DEPTH];
    logic [ATTR_W-1:0] attr_mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            pat_mem[wr_addr]  <= wr_pat;
            attr_mem[wr_addr] <= wr_attr;
        end
    end

    // registered read
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_pat  <= pat_mem[rd_addr];
            rd_attr <= attr_mem[rd_addr];
        end
    end

endmodule

[bench/bdfb_result_checker.sv]
module bdfb_result_checker
    import bdfb_pkg::*;
#(
    parameter int MAX_CELL_COLS = 128,
    parameter int MAX_CELL_ROWS = 64
)
(
    input  logic                 clk,
    input  logic                 rst_n,

    input  logic                 s_tvalid,
    input  logic                 s_tready,
    input  logic [71:0]          s_tdata,
    input  logic [2:0]           s_tuser,

    input  logic                 m_tvalid,
    input  logic                 m_tready,
    input  logic [47:0]          m_tdata,
    input  logic                 m_tuser,

    input  logic                 cfg_valid,
    input  logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [DIM_W-1:0]     cfg_data,

    output int                   mismatch_count,
    output int                   results_checked,
    output int                   awaiting
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CELL_COUNT = MAX_CELL_COLS * MAX_CELL_ROWS;

    // braille order, 3 bits per entry, entry 0 in the low bits
    localparam logic [23:0] DOT_ORDER =
        {3'd7, 3'd6, 3'd5, 3'd2, 3'd4, 3'd1, 3'd3, 3'd0};

    // command word layout, MSB first
    typedef struct packed {
        logic [6:0]  pad;
        logic [7:0]  attr_third;
        logic [7:0]  attr_second;
        logic [7:0]  attr_first;
        logic [7:0]  fill_pattern;
        logic        dot_on;
        logic [15:0] dot_y;
        logic [15:0] dot_x;
    } fb_cmd_t;

    // {m_tuser, m_tdata[46:0]}
    typedef struct packed {
        logic               in_range;
        logic [7:0]         attr_third;
        logic [7:0]         attr_second;
        logic [7:0]         attr_first;
        logic [GLYPH_W-1:0] glyph_code;
        logic [7:0]         cell_pattern;
        logic               dot_is_set;
    } cell_view_t;

    logic [PAT_W-1:0]  pattern_mem [CELL_COUNT];
    logic [ATTR_W-1:0] attr_mem [CELL_COUNT];
    logic [DIM_W-1:0]  width_q;
    logic [DIM_W-1:0]  height_q;
    cell_view_t        expected_views [$];
    int                errs;
    int                checked;

    // updates the shadow store and returns the cell view the block must report
    function automatic cell_view_t apply_command(input logic [2:0] op, input fb_cmd_t c);
        int         cols;
        int         rows;
        int         col;
        int         row;
        int         addr;
        logic       hit;
        logic [7:0] mask;
        cell_view_t v;
        cols = (int'(width_q) + 1) >> 1;
        if (cols > MAX_CELL_COLS)
            cols = MAX_CELL_COLS;
        rows = (int'(height_q) + 3) >> 2;
        if (rows > MAX_CELL_ROWS)
            rows = MAX_CELL_ROWS;
        if (op == OP_CLEAR)
        begin
            for (int i = 0; i < CELL_COUNT; i++)
            begin
                pattern_mem[i] = c.fill_pattern;
                attr_mem[i]    = '0;
            end
        end
        col  = int'(c.dot_x[15:1]);
        row  = int'(c.dot_y[15:2]);
        hit  = !c.dot_x[15] && !c.dot_y[15] && col < cols && row < rows;
        mask = 8'(1) << DOT_ORDER[int'({c.dot_y[1:0], c.dot_x[0]}) * 3 +: 3];
        v = '0;
        v.glyph_code = GLYPH_BASE;
        if (hit)
        begin
            addr = row * MAX_CELL_COLS + col;
            if (op == OP_PLOT)
                pattern_mem[addr] = c.dot_on ? (pattern_mem[addr] | mask)
                                             : (pattern_mem[addr] & ~mask);
            else if (op == OP_SETATTR)
                attr_mem[addr] = {c.attr_third, c.attr_second, c.attr_first};
            v.in_range     = 1'b1;
            v.dot_is_set   = |(pattern_mem[addr] & mask);
            v.cell_pattern = pattern_mem[addr];
            v.glyph_code   = GLYPH_BASE + GLYPH_W'(pattern_mem[addr]);
            v.attr_first   = attr_mem[addr][7:0];
            v.attr_second  = attr_mem[addr][15:8];
            v.attr_third   = attr_mem[addr][23:16];
        end
        return v;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        cell_view_t got;
        cell_view_t want;
        if (!rst_n)
        begin
            width_q  = DIM_RESET;
            height_q = DIM_RESET;
            expected_views.delete();
            errs    = 0;
            checked = 0;
            mismatch_count  <= 0;
            results_checked <= 0;
            awaiting        <= 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == CFG_AREA_W)
                    width_q = cfg_data;
                else if (cfg_index == CFG_AREA_H)
                    height_q = cfg_data;
            end

            // result first: a word accepted on this edge belongs to an older command
            if (m_tvalid && m_tready)
            begin
                got = {m_tuser, m_tdata[46:0]};
                if (expected_views.size() == 0)
                begin
                    errs++;
                    if (errs <= 10)
                        $display("%t: unexpected result word %h in_range=%0b",
                                 $realtime, m_tdata, m_tuser);
                end
                else
                begin
                    want = expected_views.pop_front();
                    checked++;
                    if (got.in_range !== want.in_range
                        || got.dot_is_set !== want.dot_is_set
                        || got.cell_pattern !== want.cell_pattern
                        || got.glyph_code !== want.glyph_code
                        || got.attr_first !== want.attr_first
                        || got.attr_second !== want.attr_second
                        || got.attr_third !== want.attr_third)
                    begin
                        errs++;
                        if (errs <= 10)
                        begin
                            $display("%t: result %0d mismatch", $realtime, checked);
                            $display("  exp rng=%b dot=%b pat=%h glyph=%h attr=%h/%h/%h",
                                     want.in_range, want.dot_is_set, want.cell_pattern,
                                     want.glyph_code, want.attr_first, want.attr_second,
                                     want.attr_third);
                            $display("  got rng=%b dot=%b pat=%h glyph=%h attr=%h/%h/%h",
                                     got.in_range, got.dot_is_set, got.cell_pattern,
                                     got.glyph_code, got.attr_first, got.attr_second,
                                     got.attr_third);
                        end
                    end
                end
            end

            if (s_tvalid && s_tready)
                expected_views.push_back(apply_command(s_tuser, s_tdata));

            mismatch_count  <= errs;
            results_checked <= checked;
            awaiting        <= expected_views.size();
        end
    end

endmodule

[bench/tb_braille_dot_framebuffer_top.sv]
module tb_braille_dot_framebuffer_top;
    timeunit 1ns;
    timeprecision 1ps;
    import bdfb_pkg::*;

    localparam int GRID_COLS       = 128;
    localparam int GRID_ROWS       = 64;
    localparam int SETTING_COUNT   = 10;
    localparam int WORDS_PER_PHASE = 103;
    // random clears are capped: each one sweeps all 8192 cells
    localparam int CLEAR_CAP       = 24;
    // worst case: ~30 clears each sweeping every cell, plus ~1050 words each waiting
    // out a long receiver stall and a sender gap; taken about four times over
    localparam int RUN_LIMIT       = 1_200_000;

    logic                 clk;
    logic                 rst_n;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [71:0]          s_tdata;
    logic [2:0]           s_tuser;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [47:0]          m_tdata;
    logic                 m_tuser;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [DIM_W-1:0]     cfg_data;

    int mismatch_count;
    int results_checked;
    int awaiting;

    int words_sent  = 0;
    int burst_left  = 0;
    int cycle_count = 0;
    int settings_used = 0;
    int op_count [8];
    int cur_width  = 256;
    int cur_height = 256;

    int stall_mode = 0;
    int stall_left = 0;

    braille_dot_framebuffer_top #(
        .MAX_CELL_COLS (GRID_COLS),
        .MAX_CELL_ROWS (GRID_ROWS)
    ) DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // watches all three channels, predicts each result word and compares
    bdfb_result_checker #(
        .MAX_CELL_COLS (GRID_COLS),
        .MAX_CELL_ROWS (GRID_ROWS)
    ) u_checker (
        .clk             (clk),
        .rst_n           (rst_n),
        .s_tvalid        (s_tvalid),
        .s_tready        (s_tready),
        .s_tdata         (s_tdata),
        .s_tuser         (s_tuser),
        .m_tvalid        (m_tvalid),
        .m_tready        (m_tready),
        .m_tdata         (m_tdata),
        .m_tuser         (m_tuser),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .mismatch_count  (mismatch_count),
        .results_checked (results_checked),
        .awaiting        (awaiting)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == RUN_LIMIT)
        begin
            $display("tb_braille_dot_framebuffer_top: done, errors");
            $finish;
        end
    end

    // receiver back-pressure: a mode is held for a random stretch, then a new
    // one is drawn (always ready, coin flip, mostly stalled, toggling)
    always @(posedge clk)
    begin
        if (stall_left == 0)
        begin
            stall_mode <= $urandom_range(0, 3);
            stall_left <= $urandom_range(8, 80);
        end
        else
            stall_left <= stall_left - 1;
        case (stall_mode)
            0:       m_tready <= 1'b1;
            1:       m_tready <= 1'($urandom_range(0, 1));
            2:       m_tready <= ($urandom_range(0, 3) == 0);
            default: m_tready <= ~m_tready;
        endcase
    end

    // Send one command word. Words go out in bursts; a new burst may open with
    // a gap of idle cycles. Long bursts with no gap at all show up too, so the
    // block sees back-to-back words as well as idle cycles at every phase.
    task automatic send_word(input logic [2:0] op, input logic [15:0] x, input logic [15:0] y,
                             input logic on, input logic [7:0] fill, input logic [7:0] a1,
                             input logic [7:0] a2, input logic [7:0] a3);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 60)
                                                     : $urandom_range(1, 12);
            gap = $urandom_range(0, 6);
            if (gap != 0)
            begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {7'd0, a3, a2, a1, fill, on, y, x};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        words_sent++;
        op_count[op]++;
    endtask

    // Random command. Coordinates mostly land inside the current grid, often
    // in a small corner window so plots pile up in a few cells; the rest are
    // fully random 16-bit values or straddle the grid's right/bottom edge.
    task automatic send_random_word();
        logic [2:0]  op;
        logic [15:0] x;
        logic [15:0] y;
        int          r;
        int          mode;
        int          cols;
        int          rows;
        int          xspan;
        int          yspan;
        r = $urandom_range(0, 199);
        if (r < 3 && op_count[OP_CLEAR] < CLEAR_CAP)
            op = OP_CLEAR;
        else if (r < 70)
            op = OP_PLOT;
        else if (r < 110)
            op = OP_TEST;
        else if (r < 140)
            op = OP_SETATTR;
        else if (r < 188)
            op = OP_READ;
        else
            op = OP_READ + 3'($urandom_range(1, 3));   // undefined opcodes

        cols  = (cur_width + 1) >> 1;
        rows  = (cur_height + 3) >> 2;
        xspan = 2 * ((cols > GRID_COLS) ? GRID_COLS : cols);
        yspan = 4 * ((rows > GRID_ROWS) ? GRID_ROWS : rows);
        mode  = $urandom_range(0, 9);
        if (mode == 0)
        begin
            x = 16'($urandom);
            y = 16'($urandom);
        end
        else if (mode == 1)
        begin
            x = 16'($urandom_range(0, xspan + 3));
            y = 16'($urandom_range(0, yspan + 7));
        end
        else if (mode <= 4)
        begin
            x = (xspan == 0) ? 16'd0 : 16'($urandom_range(0, ((xspan < 6) ? xspan : 6) - 1));
            y = (yspan == 0) ? 16'd0 : 16'($urandom_range(0, ((yspan < 8) ? yspan : 8) - 1));
        end
        else
        begin
            x = (xspan == 0) ? 16'($urandom_range(0, 3)) : 16'($urandom_range(0, xspan - 1));
            y = (yspan == 0) ? 16'($urandom_range(0, 3)) : 16'($urandom_range(0, yspan - 1));
        end
        send_word(op, x, y, 1'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
                  8'($urandom));
    endtask

    // Directed words under the reset grid (256 x 256 dots, 128 x 64 cells).
    // Starts with a clear so no cell is read before it holds a value.
    task automatic run_directed();
        send_word(OP_CLEAR, 16'd0, 16'd0, 1'b0, 8'h00, 8'h00, 8'h00, 8'h00);
        // every dot of cell (0,0): walks the whole braille bit order
        for (int yy = 0; yy < 4; yy++)
            for (int xx = 0; xx < 2; xx++)
                send_word(OP_PLOT, 16'(xx), 16'(yy), 1'b1, 8'hff, 8'hff, 8'hff, 8'hff);
        send_word(OP_PLOT, 16'd1, 16'd2, 1'b0, 8'h00, 8'h00, 8'h00, 8'h00);
        send_word(OP_TEST, 16'd1, 16'd3, 1'b0, 8'h00, 8'h00, 8'h00, 8'h00);
        // last cell of the grid
        send_word(OP_SETATTR, 16'd255, 16'd255, 1'b0, 8'h00, 8'hff, 8'h80, 8'h01);
        send_word(OP_READ, 16'd255, 16'd255, 1'b1, 8'hff, 8'h00, 8'h00, 8'h00);
        // one past the grid in x and in y
        send_word(OP_READ, 16'd256, 16'd0, 1'b0, 8'h00, 8'h00, 8'h00, 8'h00);
        send_word(OP_PLOT, 16'd0, 16'd256, 1'b1, 8'h00, 8'h00, 8'h00, 8'h00);
        // negative and largest coordinates
        send_word(OP_PLOT, 16'hffff, 16'd0, 1'b1, 8'h00, 8'h00, 8'h00, 8'h00);
        send_word(OP_TEST, 16'd0, 16'h8000, 1'b0, 8'h00, 8'h00, 8'h00, 8'h00);
        send_word(OP_READ, 16'h7fff, 16'h7fff, 1'b0, 8'h00, 8'h00, 8'h00, 8'h00);
        // undefined opcodes behave like a read
        for (int k = 1; k <= 3; k++)
            send_word(OP_READ + 3'(k), 16'd0, 16'd0, 1'b1, 8'hff, 8'hff, 8'hff, 8'hff);
        // clear reporting a cell whose attributes were set; all-ones fill
        send_word(OP_CLEAR, 16'd255, 16'd255, 1'b1, 8'hff, 8'hff, 8'hff, 8'hff);
        send_word(OP_READ, 16'd0, 16'd0, 1'b0, 8'h00, 8'h00, 8'h00, 8'h00);
    endtask

    // both registers, back to back; valid only dropped after the second word
    task automatic write_dims(input int w, input int h);
        for (int k = 0; k < 2; k++)
        begin
            cfg_valid <= 1'b1;
            cfg_index <= (k == 0) ? CFG_AREA_W : CFG_AREA_H;
            cfg_data  <= (k == 0) ? DIM_W'(w) : DIM_W'(h);
            @(posedge clk);
            while (!cfg_ready)
                @(posedge clk);
        end
        cfg_valid <= 1'b0;
        cur_width  = w;
        cur_height = h;
        settings_used++;
    endtask

    // wait until every sent word has its result back, then let the
    // write-back cycle settle before touching the registers
    task automatic drain();
        s_tvalid <= 1'b0;
        while (results_checked != words_sent)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    initial
    begin
        int w;
        int h;
        int reserved;
        foreach (op_count[i])
            op_count[i] = 0;
        rst_n     <= 1'b0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        s_tuser   <= OP_READ;
        cfg_valid <= 1'b0;
        cfg_index <= CFG_AREA_W;
        cfg_data  <= '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        run_directed();
        drain();

        // grid settings: extremes first (zero, one, full, oversized), then
        // odd sizes and random ones; back to full size at the end
        for (int p = 0; p < SETTING_COUNT; p++)
        begin
            case (p)
                0:       begin w = 255; h = 255; end
                1:       begin w = 1;   h = 1;   end
                2:       begin w = 0;   h = 256; end
                3:       begin w = 256; h = 0;   end
                4:       begin w = 511; h = 511; end
                5:       begin w = 257; h = 9;   end
                6:       begin w = 3;   h = 5;   end
                7, 8:    begin w = $urandom_range(0, 511); h = $urandom_range(0, 511); end
                default: begin w = 256; h = 256; end
            endcase
            write_dims(w, h);
            repeat (WORDS_PER_PHASE)
                send_random_word();
            drain();
        end

        repeat (8) @(posedge clk);

        reserved = 0;
        for (int k = OP_READ + 1; k < 8; k++)
            reserved += op_count[k];
        $display("covered %0d commands: %0d clears, %0d plots, %0d tests, %0d attr sets,",
                 words_sent, op_count[OP_CLEAR], op_count[OP_PLOT], op_count[OP_TEST],
                 op_count[OP_SETATTR]);
        $display("  %0d reads, %0d undefined ops; %0d grid settings; %0d mismatches",
                 op_count[OP_READ], reserved, settings_used, mismatch_count + awaiting);
        if (mismatch_count == 0 && awaiting == 0)
            $display("tb_braille_dot_framebuffer_top: done, clean");
        else
            $display("tb_braille_dot_framebuffer_top: done, errors");
        $finish;
    end

endmodule
